### rtl/core/hdu_pkg.sv
package hdu_pkg;

    // Pipeline depths
    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;

    // Datapath widths
    localparam int XW = 34;   // CORDIC and angle word
    localparam int MW = 32;   // multiplier operand
    localparam int PW = 33;   // rounded Q30 product

    typedef logic signed [XW-1:0] word_t;
    typedef logic signed [MW-1:0] mop_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic [61:0]          sq_t;
    typedef word_t                atan_tab_t [32];

    // Fixed-point constants
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
    localparam logic [31:0] ANG_K        = 32'(PI_Q62 / 64'd3600000000);
    localparam word_t       GAIN_Q30     = 34'sd652032874;
    localparam word_t       ONE_Q30      = 34'sd1073741824;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam word_t       TURN_HU      = 34'sd7200000000;
    localparam word_t       HALF_HU      = 34'sd3600000000;
    localparam word_t       QUART_HU     = 34'sd1800000000;
    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam logic [24:0] MAX_DIST     = 25'd26353589;

    // Register index carried on paddr[2]
    localparam logic REG_RADIUS = 1'b0;

    // Long division by shift and subtract, used only to build the table
    function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Arctangent of 2^-i in Q30 from the alternating series, rounded to nearest
    function automatic atan_tab_t build_atan();
        atan_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        tab[0] = XW'(((PI_Q62 >> 2) + 64'h80000000) >> 32);
        for (int i = 1; i < 32; i++)
        begin
            acc = '0;
            for (int k = 0; k < 32; k++)
            begin
                sh = 62 - i * (2 * k + 1);
                if (sh >= 0)
                begin
                    term = cdiv(64'd1 << sh, 64'(2 * k + 1));
                    if (k[0])
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
            tab[i] = XW'((acc + 64'h80000000) >> 32);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();

    // Q30 product rounded to nearest, ties upward
    function automatic prod_t mulq(input mop_t a, input mop_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return PW'(p >>> 30);
    endfunction

endpackage

### rtl/core/haversine_distance_unit.sv
// Great-circle distance between two points by the haversine formula, one
// point pair per cycle while the output side is not stalled. Latitudes and
// longitudes come in signed units of 1e-7 degree; the result is the
// distance in whole meters on a sphere whose radius sits in the
// sphere_radius_m register (address 0). The block is a single pipeline with
// no feedback: a new pair is taken every cycle while the output side is not
// stalled. The two CORDIC chains (one rotation for the sines and cosines,
// one vectoring for the arctangent) and the 31-step square root make up most
// of its depth, one stage per iteration. A stall on the output freezes the
// whole pipeline; the input side stalls only while a finished result is held.
module haversine_distance_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [30:0]   first_lat,
    input  logic signed [31:0]   first_lon,
    input  logic signed [30:0]   second_lat,
    input  logic signed [31:0]   second_lon,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [24:0]          distance_m
);
    import hdu_pkg::*;

    localparam int N  = CORDIC_STAGES;
    localparam int SQ = SQRT_STEPS;

    logic        advance;
    logic [22:0] radius_reg;

    // Input stage
    logic              in_v_reg;
    logic signed [30:0] lat1_reg, lat2_reg;
    logic signed [31:0] lon1_reg, lon2_reg;

    // Fold stage
    logic        fold_v_reg;
    logic [30:0] fold_mag_reg  [4];
    logic [3:0]  fold_neg_reg, fold_flip_reg;
    logic [30:0] fold_mag_next [4];
    logic [3:0]  fold_neg_next, fold_flip_next;
    word_t       hu [4];

    // Rotation CORDIC
    logic        rot_v_reg    [0:N];
    word_t       rot_x_reg    [0:N][4];
    word_t       rot_y_reg    [0:N][4];
    word_t       rot_z_reg    [0:N][4];
    logic [3:0]  rot_flip_reg [0:N];
    word_t       rot_x_next   [0:N][4];
    word_t       rot_y_next   [0:N][4];
    word_t       rot_z_next   [0:N][4];

    // Products
    logic  m1_v_reg, m2_v_reg;
    prod_t m1_sl_reg, m1_cc_reg, m1_sn_reg;
    prod_t m2_sl_reg, m2_t_reg;
    word_t c1, c2;

    // Square roots
    logic  sq_v_reg   [0:SQ];
    sq_t   sq_rem_reg [0:SQ][2];
    sq_t   sq_res_reg [0:SQ][2];
    sq_t   sq_rem_next [0:SQ][2];
    sq_t   sq_res_next [0:SQ][2];
    word_t a_sum;
    logic [30:0] a_clamp;

    // Vectoring CORDIC
    logic  vec_v_reg  [0:N];
    word_t vec_x_reg  [0:N];
    word_t vec_y_reg  [0:N];
    word_t vec_z_reg  [0:N];
    word_t vec_x_next [0:N];
    word_t vec_y_next [0:N];
    word_t vec_z_next [0:N];

    // Angle and output
    logic             ang_v_reg;
    logic [31:0]      ang_cang_reg;
    logic [31:0]      ang_cang_next;
    logic signed [XW:0] twice;
    logic             out_valid_reg;
    logic [24:0]      dist_reg;
    logic [55:0]      dist_prod;

    // Freeze everything while a held result is not taken
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {9'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
            radius_reg <= pwdata[22:0];
    end

    // Angles in half units, then wrap and fold into the right half plane
    always_comb
    begin
        word_t wrapped;
        word_t folded;
        word_t absval;
        logic  fl;
        hu[0] = XW'(lat1_reg) <<< 1;
        hu[1] = XW'(lat2_reg) <<< 1;
        hu[2] = XW'(lat2_reg) - XW'(lat1_reg);
        hu[3] = XW'(lon2_reg) - XW'(lon1_reg);
        for (int l = 0; l < 4; l++)
        begin
            wrapped = hu[l];
            if (wrapped >= HALF_HU)
                wrapped = wrapped - TURN_HU;
            else if (wrapped < -HALF_HU)
                wrapped = wrapped + TURN_HU;
            folded = wrapped;
            fl     = 1'b0;
            if (folded > QUART_HU)
            begin
                folded = HALF_HU - folded;
                fl     = 1'b1;
            end
            else if (folded < -QUART_HU)
            begin
                folded = -HALF_HU - folded;
                fl     = 1'b1;
            end
            absval            = folded[XW-1] ? -folded : folded;
            fold_neg_next[l]  = folded[XW-1];
            fold_flip_next[l] = fl;
            fold_mag_next[l]  = absval[30:0];
        end
    end

    // Convert to Q30 radians and seed the rotation chain; run its stages
    always_comb
    begin
        logic [63:0] zp;
        word_t       zs;
        for (int l = 0; l < 4; l++)
        begin
            zp = 64'(fold_mag_reg[l]) * 64'(ANG_K) + 64'h80000000;
            zs = word_t'({2'b00, zp[63:32]});
            rot_x_next[0][l] = GAIN_Q30;
            rot_y_next[0][l] = '0;
            rot_z_next[0][l] = fold_neg_reg[l] ? -zs : zs;
        end
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (!rot_z_reg[k][l][XW-1])
                begin
                    rot_x_next[k+1][l] = rot_x_reg[k][l] - (rot_y_reg[k][l] >>> k);
                    rot_y_next[k+1][l] = rot_y_reg[k][l] + (rot_x_reg[k][l] >>> k);
                    rot_z_next[k+1][l] = rot_z_reg[k][l] - ATAN_TAB[k];
                end
                else
                begin
                    rot_x_next[k+1][l] = rot_x_reg[k][l] + (rot_y_reg[k][l] >>> k);
                    rot_y_next[k+1][l] = rot_y_reg[k][l] - (rot_x_reg[k][l] >>> k);
                    rot_z_next[k+1][l] = rot_z_reg[k][l] + ATAN_TAB[k];
                end
            end
        end
    end

    // Cosines of the latitudes, negated where the fold reflected an angle beyond 90 degrees
    assign c1 = rot_flip_reg[N][0] ? -rot_x_reg[N][0] : rot_x_reg[N][0];
    assign c2 = rot_flip_reg[N][1] ? -rot_x_reg[N][1] : rot_x_reg[N][1];

    // Sum the haversine terms, clamp, and seed both square roots
    always_comb
    begin
        sq_t bitv;
        sq_t sum;
        a_sum = XW'(m2_sl_reg) + XW'(m2_t_reg);
        if (a_sum[XW-1])
            a_clamp = '0;
        else if (a_sum > ONE_Q30)
            a_clamp = ONE_Q30[30:0];
        else
            a_clamp = a_sum[30:0];
        sq_rem_next[0][0] = sq_t'(a_clamp) << 30;
        sq_rem_next[0][1] = sq_t'(ONE_Q30[30:0] - a_clamp) << 30;
        sq_res_next[0][0] = '0;
        sq_res_next[0][1] = '0;
        for (int j = 0; j < SQ; j++)
        begin
            bitv = sq_t'(1) << (2 * (SQ - 1 - j));
            for (int l = 0; l < 2; l++)
            begin
                sum = sq_res_reg[j][l] + bitv;
                if (sq_rem_reg[j][l] >= sum)
                begin
                    sq_rem_next[j+1][l] = sq_rem_reg[j][l] - sum;
                    sq_res_next[j+1][l] = (sq_res_reg[j][l] >> 1) + bitv;
                end
                else
                begin
                    sq_rem_next[j+1][l] = sq_rem_reg[j][l];
                    sq_res_next[j+1][l] = sq_res_reg[j][l] >> 1;
                end
            end
        end
    end

    // Vectoring chain: angle of (sqrt(1-a), sqrt(a))
    always_comb
    begin
        vec_x_next[0] = XW'(sq_res_reg[SQ][1]);
        vec_y_next[0] = XW'(sq_res_reg[SQ][0]);
        vec_z_next[0] = '0;
        for (int k = 0; k < N; k++)
        begin
            if (!vec_y_reg[k][XW-1])
            begin
                vec_x_next[k+1] = vec_x_reg[k] + (vec_y_reg[k] >>> k);
                vec_y_next[k+1] = vec_y_reg[k] - (vec_x_reg[k] >>> k);
                vec_z_next[k+1] = vec_z_reg[k] + ATAN_TAB[k];
            end
            else
            begin
                vec_x_next[k+1] = vec_x_reg[k] - (vec_y_reg[k] >>> k);
                vec_y_next[k+1] = vec_y_reg[k] + (vec_x_reg[k] >>> k);
                vec_z_next[k+1] = vec_z_reg[k] - ATAN_TAB[k];
            end
        end
    end

    // Central angle, doubled and clamped to [0, pi]
    always_comb
    begin
        twice = {vec_z_reg[N], 1'b0};
        if (twice[XW])
            ang_cang_next = '0;
        else if (twice[XW-1:0] > {2'b00, PI_Q30})
            ang_cang_next = PI_Q30;
        else
            ang_cang_next = twice[31:0];
    end

    // Scale by the radius and round to whole meters
    assign dist_prod = 56'(radius_reg) * 56'(ang_cang_reg) + (56'd1 << 29);

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg      <= 1'b0;
            fold_v_reg    <= 1'b0;
            m1_v_reg      <= 1'b0;
            m2_v_reg      <= 1'b0;
            ang_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
            begin
                rot_v_reg[k] <= 1'b0;
                vec_v_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= SQ; j++)
                sq_v_reg[j] <= 1'b0;
        end
        else if (advance)
        begin
            in_v_reg     <= in_valid;
            fold_v_reg   <= in_v_reg;
            rot_v_reg[0] <= fold_v_reg;
            for (int k = 0; k < N; k++)
                rot_v_reg[k+1] <= rot_v_reg[k];
            m1_v_reg    <= rot_v_reg[N];
            m2_v_reg    <= m1_v_reg;
            sq_v_reg[0] <= m2_v_reg;
            for (int j = 0; j < SQ; j++)
                sq_v_reg[j+1] <= sq_v_reg[j];
            vec_v_reg[0] <= sq_v_reg[SQ];
            for (int k = 0; k < N; k++)
                vec_v_reg[k+1] <= vec_v_reg[k];
            ang_v_reg     <= vec_v_reg[N];
            out_valid_reg <= ang_v_reg;
        end
    end

    // Payload registers advance with the valid bits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lat1_reg      <= first_lat;
            lon1_reg      <= first_lon;
            lat2_reg      <= second_lat;
            lon2_reg      <= second_lon;
            fold_mag_reg  <= fold_mag_next;
            fold_neg_reg  <= fold_neg_next;
            fold_flip_reg <= fold_flip_next;
            rot_flip_reg[0] <= fold_flip_reg;
            for (int k = 0; k <= N; k++)
            begin
                rot_x_reg[k] <= rot_x_next[k];
                rot_y_reg[k] <= rot_y_next[k];
                rot_z_reg[k] <= rot_z_next[k];
                vec_x_reg[k] <= vec_x_next[k];
                vec_y_reg[k] <= vec_y_next[k];
                vec_z_reg[k] <= vec_z_next[k];
            end
            for (int k = 0; k < N; k++)
                rot_flip_reg[k+1] <= rot_flip_reg[k];
            m1_sl_reg <= mulq(MW'(rot_y_reg[N][2]), MW'(rot_y_reg[N][2]));
            m1_cc_reg <= mulq(MW'(c1), MW'(c2));
            m1_sn_reg <= mulq(MW'(rot_y_reg[N][3]), MW'(rot_y_reg[N][3]));
            m2_sl_reg <= m1_sl_reg;
            m2_t_reg  <= mulq(MW'(m1_cc_reg), MW'(m1_sn_reg));
            for (int j = 0; j <= SQ; j++)
            begin
                sq_rem_reg[j] <= sq_rem_next[j];
                sq_res_reg[j] <= sq_res_next[j];
            end
            ang_cang_reg <= ang_cang_next;
            dist_reg     <= dist_prod[54:30];
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance_m = dist_reg;

endmodule

### rtl/core/hdu_checker.sv
module hdu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [2:0]           paddr,
    input logic [31:0]          pwdata,
    input logic [31:0]          prdata,
    input logic                 pready,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic signed [30:0]   first_lat,
    input logic signed [31:0]   first_lon,
    input logic signed [30:0]   second_lat,
    input logic signed [31:0]   second_lon,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [24:0]          distance_m
);
    import hdu_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_m))
        else $error("stalled result changed or dropped");

    // Stall the input only while a held result blocks the output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Keep the distance within half the largest circumference
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= MAX_DIST)
        else $error("distance beyond half circumference");

    // Complete every register access without wait states
    a_apb_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("register access not ready");

endmodule

bind haversine_distance_unit hdu_checker u_hdu_checker (.*);

### verif/hdu_distance_check.sv
module hdu_distance_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [30:0]   first_lat,
    input  logic signed [31:0]   first_lon,
    input  logic signed [30:0]   second_lat,
    input  logic signed [31:0]   second_lon,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [24:0]          distance_m,
    output int                   errors,
    output int                   pending
);
    import hdu_pkg::*;

    localparam longint unsigned PI62   = 64'hC90FDAA22168C235;
    localparam longint unsigned ANGK   = PI62 / 64'd3600000000;
    localparam longint          PI30   = 64'sd3373259426;
    localparam longint          ONE30  = 64'sd1073741824;
    localparam longint          SEED_X = 64'sd652032874;
    localparam longint          TURN   = 64'sd7200000000;
    localparam longint          HALF   = 64'sd3600000000;
    localparam longint          QUART  = 64'sd1800000000;

    longint         arctan_q30 [32];
    logic [22:0]    radius;
    logic [24:0]    dist_queue [$];

    // Build atan(2^-i) in Q30 from the alternating series
    initial
    begin
        longint unsigned acc;
        longint unsigned term;
        int              sh;
        arctan_q30[0] = longint'(((PI62 >> 2) + 64'h80000000) >> 32);
        for (int i = 1; i < 32; i++)
        begin
            acc = 0;
            for (int k = 0; k < 40; k++)
            begin
                sh = 62 - i * (2 * k + 1);
                if (sh >= 0)
                begin
                    term = (64'd1 << sh) / longint'(2 * k + 1);
                    if (k % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
            arctan_q30[i] = longint'((acc + 64'h80000000) >> 32);
        end
    end

    function automatic longint mul30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rotate the seed vector by an angle given in half units of 1e-7 degree
    task automatic rotate_hu(input longint hu, output longint s, output longint c);
        longint          r;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        bit              flip;
        longint unsigned mag;
        r    = hu % TURN;
        x    = SEED_X;
        y    = 0;
        flip = 1'b0;
        if (r >= HALF)
            r = r - TURN;
        else if (r < -HALF)
            r = r + TURN;
        if (r > QUART)
        begin
            r    = HALF - r;
            flip = 1'b1;
        end
        else if (r < -QUART)
        begin
            r    = -HALF - r;
            flip = 1'b1;
        end
        mag = (r < 0) ? longint'(-r) : longint'(r);
        z   = longint'((mag * ANGK + 64'h80000000) >> 32);
        if (r < 0)
            z = -z;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q30[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q30[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q30[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q30[i];
            end
        end
        return z;
    endfunction

    task automatic great_circle(input longint lat1, input longint lon1, input longint lat2,
                                input longint lon2, input logic [22:0] rad,
                                output logic [24:0] dist_out);
        longint          s1, c1, s2, c2, sl, cl, sn, cn, a, ang;
        longint unsigned ys, xs, prod;
        rotate_hu(2 * lat1, s1, c1);
        rotate_hu(2 * lat2, s2, c2);
        rotate_hu(lat2 - lat1, sl, cl);
        rotate_hu(lon2 - lon1, sn, cn);
        a = mul30(sl, sl) + mul30(mul30(c1, c2), mul30(sn, sn));
        if (a < 0)
            a = 0;
        if (a > ONE30)
            a = ONE30;
        ys  = root_floor(longint'(a) << 30);
        xs  = root_floor(longint'(ONE30 - a) << 30);
        ang = 2 * vector_angle(longint'(ys), longint'(xs));
        if (ang < 0)
            ang = 0;
        if (ang > PI30)
            ang = PI30;
        prod     = longint'(rad) * longint'(ang) + (64'd1 << 29);
        dist_out = 25'(prod >> 30);
    endtask

    assign pending = dist_queue.size();

    // Track the radius register, predict each input transfer, check each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        logic [24:0] want;
        if (!rst_n)
        begin
            radius = RADIUS_RESET;
            dist_queue.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
                radius = pwdata[22:0];
            if (in_valid && !in_stall)
            begin
                great_circle(longint'(first_lat), longint'(first_lon), longint'(second_lat),
                             longint'(second_lon), radius, want);
                dist_queue.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (dist_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected distance transfer: actual %0d", distance_m);
                end
                else
                begin
                    want = dist_queue.pop_front();
                    if (want !== distance_m)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("distance_m mismatch: expected %0d actual %0d",
                                     want, distance_m);
                    end
                end
            end
        end
    end
endmodule

### verif/tb_top.sv
module tb_top;
    import hdu_pkg::*;

    localparam longint LAT_MAX = 900000000;
    localparam longint LON_MAX = 1800000000;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [30:0]   first_lat;
    logic signed [31:0]   first_lon;
    logic signed [30:0]   second_lat;
    logic signed [31:0]   second_lon;
    logic                 out_valid;
    logic                 out_stall;
    logic [24:0]          distance_m;
    int                   errors;
    int                   pending;
    bit                   quiet;
    bit                   hold_req;

    haversine_distance_unit u_top (.*);

    hdu_distance_check u_dist_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(4 * 1000000);
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one point pair and hold it until the transfer
    task automatic send_pair(input longint lat1, input longint lon1, input longint lat2,
                             input longint lon2);
        in_valid   <= 1'b1;
        first_lat  <= 31'(lat1);
        first_lon  <= 32'(lon1);
        second_lat <= 31'(lat2);
        second_lon <= 32'(lon2);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drop valid and let the last transfer be counted, then wait for every result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (120) @(posedge clk);
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(0, 1800000000)) - LAT_MAX;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - LON_MAX;
    endfunction

    // Mostly in-range pairs, some close or near-antipodal, some full-width noise
    task automatic random_pair();
        longint la1, lo1, la2, lo2;
        int     mode;
        mode = $urandom_range(0, 9);
        la1  = rand_lat();
        lo1  = rand_lon();
        la2  = rand_lat();
        lo2  = rand_lon();
        if (mode < 2)
        begin
            la2 = la1 + $urandom_range(0, 2000) - 1000;
            lo2 = lo1 + $urandom_range(0, 2000) - 1000;
        end
        else if (mode == 2)
        begin
            la2 = -la1 + $urandom_range(0, 200) - 100;
            lo2 = lo1 + LON_MAX + $urandom_range(0, 200) - 100;
        end
        else if (mode == 3)
        begin
            la1 = longint'(31'sh0 + $signed(31'($urandom())));
            lo1 = longint'($signed($urandom()));
            la2 = longint'(31'sh0 + $signed(31'($urandom())));
            lo2 = longint'($signed($urandom()));
        end
        send_pair(la1, lo1, la2, lo2);
        sender_gap();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        first_lat  = '0;
        first_lon  = '0;
        second_lat = '0;
        second_lon = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, coincident, antipodal, poles, wrap beyond range
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, 123, LAT_MAX, -456789);
        send_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
        send_pair(450000000, 900000000, -450000000, -900000000);
        send_pair(123456789, -987654321, 123456789, -987654321);
        send_pair(1073741823, 2147483647, -1073741824, -2147483648);
        send_pair(-1073741824, -2147483648, 1073741823, 2147483647);
        send_pair(1073741823, 0, 0, 0);
        send_pair(0, 2147483647, 0, -2147483648);
        send_pair(1, 1, -1, -1);
        send_pair(0, 0, 1, 0);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        drain();

        // Radius sweep including zero and the extremes, plus a write past the register
        reg_write({~REG_RADIUS, 2'b00}, 32'hFFFF_FFFF);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, 0, 450000000, 0);
        drain();
        reg_write({REG_RADIUS, 2'b00}, 32'd1);
        send_pair(0, 0, 0, LON_MAX);
        repeat (20) random_pair();
        drain();
        reg_write({REG_RADIUS, 2'b00}, 32'd8388607);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, 0, 0, LON_MAX);
        repeat (60) random_pair();
        drain();
        reg_write({REG_RADIUS, 2'b00}, 32'd0);
        send_pair(0, 0, 0, LON_MAX);
        repeat (10) random_pair();
        drain();

        // Long receiver hold-off while pairs keep coming
        reg_write({REG_RADIUS, 2'b00}, 32'd6371000);
        hold_req = 1'b1;
        repeat (160) random_pair();
        drain();

        reg_write({REG_RADIUS, 2'b00}, 32'($urandom_range(1, 8388607)));
        repeat (80) random_pair();

        // Final stretch with no idling on either side
        quiet = 1'b1;
        repeat (70) random_pair();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

### haversine_distance_unit.f
rtl/core/hdu_pkg.sv
rtl/core/haversine_distance_unit.sv
rtl/core/hdu_checker.sv
verif/hdu_distance_check.sv
verif/tb_top.sv
